// File: src/jse_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// JSON string escaper package
// Shared request codes, queue entry type and escape character helpers.
// ----------------------------------------------------------------------------
package jse_pkg;

    // Request codes on the input channel.
    localparam logic [1:0] REQ_BEGIN = 2'd0;
    localparam logic [1:0] REQ_DATA  = 2'd1;
    localparam logic [1:0] REQ_END   = 2'd2;

    // Largest byte that still needs escaping as a control character.
    localparam logic [7:0] CTRL_MAX = 8'h1f;

    // Depth of the queue between front and back.
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Characters used in the output text.
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_ZERO   = 8'h30;

    // Shape of the output run that one item causes.
    typedef enum logic [1:0] {
        KIND_LIT  = 2'd0,   // one byte, sent as it is
        KIND_PAIR = 2'd1,   // backslash followed by one character
        KIND_UNI  = 2'd2    // backslash, u, two zeros and two hex digits
    } t_kind;

    // One classified item as held in the queue.
    typedef struct packed {
        t_kind      kind;
        logic [7:0] arg;
    } t_entry;

    // Queue status seen by the front and the back.
    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    // Lowercase hex digit for a nibble.
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < 4'd10) begin
            c = CH_ZERO + {4'd0, nib};
        end else begin
            c = 8'h57 + {4'd0, nib};
        end
        return c;
    endfunction

    // Index of the last byte in the run for a given kind.
    function automatic logic [2:0] last_pos(input t_kind kind);
        logic [2:0] p;
        unique case (kind)
            KIND_LIT:  p = 3'd0;
            KIND_PAIR: p = 3'd1;
            KIND_UNI:  p = 3'd5;
            default:   p = 3'd0;
        endcase
        return p;
    endfunction

    // Byte at a given position of the run.
    function automatic logic [7:0] run_char(input t_entry e, input logic [2:0] pos);
        logic [7:0] c;
        c = e.arg;
        unique case (e.kind)
            KIND_LIT: begin
                c = e.arg;
            end
            KIND_PAIR: begin
                c = (pos == 3'd0) ? CH_BSLASH : e.arg;
            end
            KIND_UNI: begin
                case (pos)
                    3'd0:    c = CH_BSLASH;
                    3'd1:    c = CH_U;
                    3'd2:    c = CH_ZERO;
                    3'd3:    c = CH_ZERO;
                    3'd4:    c = hex_char(e.arg[7:4]);
                    default: c = hex_char(e.arg[3:0]);
                endcase
            end
            default: begin
                c = e.arg;
            end
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

// File: src/jse_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Escaper item queue
// Short first-word-fall-through queue between the classifier and the expander.
// ----------------------------------------------------------------------------
module jse_queue
    import jse_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire t_entry        i_entry,
    input  wire logic          i_pop,
    output t_entry             o_head,
    output t_queue_status      o_status
);

    t_entry                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wr_ptr;
    logic [QUEUE_AW-1:0]   r_rd_ptr;
    logic [QUEUE_AW:0]     r_count;
    logic                  w_do_push;
    logic                  w_do_pop;

    assign o_status.full  = (r_count == QUEUE_AW'(0) + (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign w_do_push      = i_push && !o_status.full;
    assign w_do_pop       = i_pop && !o_status.empty;
    assign o_head         = r_mem[r_rd_ptr];

    // Storage is written at the tail only.
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= r_wr_ptr + QUEUE_AW'(1);
            end
            if (w_do_pop) begin
                r_rd_ptr <= r_rd_ptr + QUEUE_AW'(1);
            end
            case ({w_do_push, w_do_pop})
                2'b10:   r_count <= r_count + (QUEUE_AW+1)'(1);
                2'b01:   r_count <= r_count - (QUEUE_AW+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

// File: src/jse_classify.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Escaper front end
// Accepts input items and sorts each into the shape of its output run.
// ----------------------------------------------------------------------------
module jse_classify
    import jse_pkg::*;
(
    input  wire logic          i_valid,
    output      logic          o_stall,
    input  wire logic [1:0]    i_req_type,
    input  wire logic [7:0]    i_data_byte,
    input  wire t_queue_status i_status,
    output      logic          o_push,
    output t_entry             o_entry
);

    logic w_known;

    // The front stalls only when the queue has no room.
    assign o_stall = i_status.full;

    // Unused request codes are taken and dropped.
    assign w_known = (i_req_type == REQ_BEGIN) || (i_req_type == REQ_DATA) ||
                     (i_req_type == REQ_END);
    assign o_push  = i_valid && !i_status.full && w_known;

    // Classify the byte into its escape form.
    always_comb begin
        o_entry.kind = KIND_LIT;
        o_entry.arg  = i_data_byte;
        if (i_req_type != REQ_DATA) begin
            o_entry.arg = CH_QUOTE;
        end else begin
            case (i_data_byte)
                CH_BSLASH, CH_QUOTE: o_entry.kind = KIND_PAIR;
                8'h08: begin
                    o_entry.kind = KIND_PAIR;
                    o_entry.arg  = 8'h62;   // b
                end
                8'h09: begin
                    o_entry.kind = KIND_PAIR;
                    o_entry.arg  = 8'h74;   // t
                end
                8'h0a: begin
                    o_entry.kind = KIND_PAIR;
                    o_entry.arg  = 8'h6e;   // n
                end
                8'h0c: begin
                    o_entry.kind = KIND_PAIR;
                    o_entry.arg  = 8'h66;   // f
                end
                8'h0d: begin
                    o_entry.kind = KIND_PAIR;
                    o_entry.arg  = 8'h72;   // r
                end
                default: begin
                    if (i_data_byte <= CTRL_MAX) begin
                        o_entry.kind = KIND_UNI;
                    end
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// File: src/jse_expand.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Escaper back end
// Walks each queued item through its output run into the output register.
// ----------------------------------------------------------------------------
module jse_expand
    import jse_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire t_entry        i_head,
    input  wire t_queue_status i_status,
    output      logic          o_pop,
    output      logic          o_valid,
    input  wire logic          i_stall,
    output      logic [7:0]    o_out_byte,
    output      logic          o_last_of_run,
    output      logic [2:0]    o_pos
);

    logic [2:0] r_pos;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_last;
    logic       w_load;
    logic       w_last;

    // The output register takes a new byte when it is empty or being taken.
    assign w_load = !r_valid || !i_stall;
    assign w_last = (r_pos == last_pos(i_head.kind));
    assign o_pop  = w_load && !i_status.empty && w_last;

    // Run position counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (w_load && !i_status.empty) begin
            r_pos <= w_last ? 3'd0 : r_pos + 3'd1;
        end
    end

    // Output register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= !i_status.empty;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (w_load && !i_status.empty) begin
            r_byte <= run_char(i_head, r_pos);
            r_last <= w_last;
        end
    end

    assign o_valid       = r_valid;
    assign o_out_byte    = r_byte;
    assign o_last_of_run = r_last;
    assign o_pos         = r_pos;

endmodule
`default_nettype wire

// File: src/json_string_escaper.sv
`default_nettype none
// ----------------------------------------------------------------------------
// JSON string escaper
// Turns begin, data and end items into the bytes of an escaped JSON string.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (i_valid, o_stall, i_req_type, i_data_byte) takes one
// item per cycle while o_stall is low. A begin or end item gives a double
// quote, a data item gives its escaped form of one, two or six bytes, and
// request code three is taken and gives nothing.
// The output channel (o_valid, i_stall, o_out_byte, o_last_of_run) gives one
// byte per cycle while i_stall is low; o_last_of_run marks the last byte of
// each item's run. With the queue empty, an accepted item is first written
// into the queue and its first byte is then loaded from the queue head into
// the output register. Throughput is one output byte per cycle while i_stall
// is low, set by the expander walking one run position each cycle; items of
// one byte each therefore flow at one per cycle, and a six-byte escape holds
// the expander until its last byte is loaded while the four-entry queue keeps
// taking items. When the receiver stalls, the output byte holds and the queue
// fills; once it is full o_stall rises. Synchronous reset empties the queue
// and the output register and clears the run position.
// ----------------------------------------------------------------------------
module json_string_escaper
    import jse_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output      logic          o_stall,
    input  wire logic [1:0]    i_req_type,
    input  wire logic [7:0]    i_data_byte,
    output      logic          o_valid,
    input  wire logic          i_stall,
    output      logic [7:0]    o_out_byte,
    output      logic          o_last_of_run
);

    t_entry        w_entry;
    t_entry        w_head;
    t_queue_status w_status;
    logic          w_push;
    logic          w_pop;
    logic [2:0]    w_pos;

    // Front end: accept and classify.
    jse_classify u_classify (
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_req_type  (i_req_type),
        .i_data_byte (i_data_byte),
        .i_status    (w_status),
        .o_push      (w_push),
        .o_entry     (w_entry)
    );

    // Queue between the two halves.
    jse_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_entry  (w_entry),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_status (w_status)
    );

    // Back end: expand into output bytes.
    jse_expand u_expand (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (w_head),
        .i_status      (w_status),
        .o_pop         (w_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_byte    (o_out_byte),
        .o_last_of_run (o_last_of_run),
        .o_pos         (w_pos)
    );

    // A pushed item leaves the queue non-empty on the next cycle.
    a_push_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |=> !w_status.empty)
        else $error("queue empty after an item was pushed");

    // The run position never passes the longest escape.
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pos <= 3'd5)
        else $error("run position out of range");

    // A run in progress always has its item at the queue head.
    a_run_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pos != 3'd0 |-> !w_status.empty)
        else $error("run in progress with an empty queue");

    // Reset leaves the output channel idle.
    a_reset_idle: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_valid)
        else $error("output valid straight after reset");

endmodule
`default_nettype wire
